// ----- rtl/exact_match_route_table_core_assert.svh -----
// Assertion macros for the exact-match route table checker.
// Depends on nothing; included by the checker module.
`ifndef EXACT_MATCH_ROUTE_TABLE_CORE_ASSERT_SVH
`define EXACT_MATCH_ROUTE_TABLE_CORE_ASSERT_SVH

// Same-cycle implication.
`define EMRT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("route table assertion failed");

// Next-cycle implication.
`define EMRT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("route table assertion failed");

`endif

// ----- rtl/emrt_pkg.sv -----
// Shared types and constants of the exact-match route table.
// Depends on nothing; used by every module of the block.
`default_nettype none

package emrt_pkg;

   localparam int MAX_ENTRIES = 16;
   localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
   localparam int RES_W       = 5;

   typedef enum logic [1:0] {
      FN_LOOKUP = 2'd0,
      FN_ADD    = 2'd1,
      FN_UPDATE = 2'd2,
      FN_DELETE = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_FULL = 2'd1,
      ST_DUP  = 2'd2,
      ST_MISS = 2'd3
   } status_type;

   typedef struct packed {
      logic [31:0] dest;
      logic [5:0]  prefix;
      logic [31:0] gateway;
      logic [7:0]  iface;
   } entry_type;

   typedef struct packed {
      logic live;
      logic capture;
      logic wr_entry;
      logic wr_route;
      logic shift;
   } cell_ctrl_type;

endpackage

`default_nettype wire

// ----- rtl/emrt_cell.sv -----
// One slot of the route table: holds a route, matches the probe key and
// takes its upper neighbour's route on a delete. Depends on emrt_pkg.
`default_nettype none

module emrt_cell (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire emrt_pkg::cell_ctrl_type ctrl,
   input  wire emrt_pkg::entry_type    probe,
   input  wire emrt_pkg::entry_type    wr_data,
   input  wire emrt_pkg::entry_type    next_entry,
   input  wire logic                   hit_in,
   output logic                        hit_out,
   output logic                        first,
   output emrt_pkg::entry_type         entry
);

   logic                match_ff;
   logic                match_in;
   emrt_pkg::entry_type entry_ff;
   emrt_pkg::entry_type entry_in;

   always_comb begin
      match_in = ctrl.live && (entry_ff.dest == probe.dest) &&
                 (entry_ff.prefix == probe.prefix);
      entry_in = entry_ff;
      if (ctrl.wr_entry) begin
         entry_in = wr_data;
      end else if (ctrl.wr_route) begin
         entry_in.gateway = wr_data.gateway;
         entry_in.iface   = wr_data.iface;
      end else if (ctrl.shift) begin
         entry_in = next_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 1'b0;
      end else if (ctrl.capture) begin
         match_ff <= match_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign hit_out = hit_in | match_ff;
   assign first   = match_ff & ~hit_in;
   assign entry   = entry_ff;

endmodule

`default_nettype wire

// ----- rtl/exact_match_route_table_core.sv -----
// Exact-match route table: lookup, add, update and delete of routes.
// A request is registered on acceptance as the cell row compares its key;
// S_EXEC then writes or shifts the cells and registers the response, but
// waits while an earlier response is held. Only S_IDLE takes a request.
// Reset clears the entry count, the controller and the response valid;
// slot contents are not cleared. Depends on emrt_pkg and emrt_cell.
`default_nettype none

module exact_match_route_table_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_func,
   input  wire logic [31:0] req_dest_addr,
   input  wire logic [5:0]  req_prefix_len,
   input  wire logic [31:0] req_next_hop,
   input  wire logic [7:0]  req_out_iface,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_status,
   output logic [4:0]       rsp_result_value
);

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

   state_type                     state_ff, state_in;
   logic [emrt_pkg::CNT_W-1:0]    count_ff, count_in;
   emrt_pkg::func_type            func_ff, func_in;
   emrt_pkg::entry_type           req_ff, req_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   emrt_pkg::status_type          status_ff, status_in;
   logic [emrt_pkg::RES_W-1:0]    value_ff, value_in;

   emrt_pkg::entry_type           probe;
   emrt_pkg::entry_type           cell_entry [emrt_pkg::MAX_ENTRIES];
   emrt_pkg::cell_ctrl_type       cell_ctrl  [emrt_pkg::MAX_ENTRIES];
   logic [emrt_pkg::MAX_ENTRIES:0] hit_chain;
   logic [emrt_pkg::MAX_ENTRIES-1:0] first;
   logic [emrt_pkg::IDX_W-1:0]    pos;
   logic                          accept, go, hit, full;
   logic                          wr_add, wr_upd, do_del;

   assign probe = '{dest: req_dest_addr, prefix: req_prefix_len,
                    gateway: req_next_hop, iface: req_out_iface};

   assign hit_chain[0] = 1'b0;

   for (genvar g = 0; g < emrt_pkg::MAX_ENTRIES; g++) begin : g_cell
      emrt_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (cell_ctrl[g]),
         .probe      (probe),
         .wr_data    (req_ff),
         .next_entry ((g == emrt_pkg::MAX_ENTRIES - 1) ? cell_entry[g]
                                                         : cell_entry[(g + 1) % emrt_pkg::MAX_ENTRIES]),
         .hit_in     (hit_chain[g]),
         .hit_out    (hit_chain[g+1]),
         .first      (first[g]),
         .entry      (cell_entry[g])
      );
   end

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign go        = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_ready);
   assign hit       = hit_chain[emrt_pkg::MAX_ENTRIES];
   assign full      = (count_ff == emrt_pkg::CNT_W'(emrt_pkg::MAX_ENTRIES));

   always_comb begin
      pos = '0;
      for (int i = 0; i < emrt_pkg::MAX_ENTRIES; i++) begin
         if (first[i]) begin
            pos = pos | emrt_pkg::IDX_W'(i);
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      func_in      = func_ff;
      req_in       = req_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      status_in    = status_ff;
      value_in     = value_ff;
      wr_add       = 1'b0;
      wr_upd       = 1'b0;
      do_del       = 1'b0;
      if (accept) begin
         state_in = S_EXEC;
         func_in  = emrt_pkg::func_type'(req_func);
         req_in   = probe;
      end
      if (go) begin
         state_in     = S_IDLE;
         rsp_valid_in = 1'b1;
         status_in    = emrt_pkg::ST_OK;
         value_in     = '0;
         unique case (func_ff)
            emrt_pkg::FN_LOOKUP: begin
               if (hit) begin
                  value_in = emrt_pkg::RES_W'(pos);
               end else begin
                  status_in = emrt_pkg::ST_MISS;
               end
            end
            emrt_pkg::FN_ADD: begin
               if (full) begin
                  status_in = emrt_pkg::ST_FULL;
               end else if (hit) begin
                  status_in = emrt_pkg::ST_DUP;
               end else begin
                  wr_add   = 1'b1;
                  count_in = count_ff + emrt_pkg::CNT_W'(1);
                  value_in = emrt_pkg::RES_W'(count_ff);
               end
            end
            emrt_pkg::FN_UPDATE: begin
               if (hit) begin
                  wr_upd   = 1'b1;
                  value_in = emrt_pkg::RES_W'(pos);
               end else begin
                  status_in = emrt_pkg::ST_MISS;
               end
            end
            emrt_pkg::FN_DELETE: begin
               if (hit) begin
                  do_del   = 1'b1;
                  count_in = count_ff - emrt_pkg::CNT_W'(1);
                  value_in = emrt_pkg::RES_W'(count_ff - emrt_pkg::CNT_W'(1));
               end else begin
                  status_in = emrt_pkg::ST_MISS;
               end
            end
            default: begin
               status_in = emrt_pkg::ST_MISS;
            end
         endcase
      end
   end

   always_comb begin
      for (int i = 0; i < emrt_pkg::MAX_ENTRIES; i++) begin
         cell_ctrl[i].live     = (emrt_pkg::CNT_W'(i) < count_ff);
         cell_ctrl[i].capture  = accept;
         cell_ctrl[i].wr_entry = wr_add && (emrt_pkg::CNT_W'(i) == count_ff);
         cell_ctrl[i].wr_route = wr_upd && first[i];
         cell_ctrl[i].shift    = do_del && hit_chain[i+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      func_ff   <= func_in;
      req_ff    <= req_in;
      status_ff <= status_in;
      value_ff  <= value_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_result_value = value_ff;

endmodule

`default_nettype wire

// ----- rtl/emrt_checker.sv -----
// Port-level checks of the exact-match route table, bound to the top level.
// Depends on emrt_pkg and the assertion macro header.
`default_nettype none
`include "exact_match_route_table_core_assert.svh"

module emrt_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [1:0] rsp_status,
   input wire logic [4:0] rsp_result_value
);

   logic rsp_stall;
   logic rsp_error;

   assign rsp_stall = rsp_valid && !rsp_ready;
   assign rsp_error = rsp_status != emrt_pkg::ST_OK;

   `EMRT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid)
   `EMRT_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_stall, $stable(rsp_status) && $stable(rsp_result_value))
   `EMRT_ASSERT_NOW(a_err_zero, clock, reset, rsp_valid && rsp_error, rsp_result_value == 5'd0)
   `EMRT_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_valid && req_ready, !req_ready)
   `EMRT_ASSERT_NOW(a_value_range, clock, reset, rsp_valid, rsp_result_value <= 5'(emrt_pkg::MAX_ENTRIES))

endmodule

bind exact_match_route_table_core emrt_checker u_emrt_checker (.*);

`default_nettype wire
